// ===== rtl/core/lvf_pkg.sv =====
`timescale 1ns / 1ps

package lvf_pkg;

  // Scaling mode codes.
  localparam logic [2:0] MODE_KEEP_ASPECT = 3'd0;
  localparam logic [2:0] MODE_STRETCH     = 3'd1;
  localparam logic [2:0] MODE_CENTER      = 3'd2;
  localparam logic [2:0] MODE_CENTER_INT  = 3'd3;

  // Configuration register indexes.
  localparam logic REG_FIT_MODE      = 1'b0;
  localparam logic REG_NATIVE_RENDER = 1'b1;

  // Percent divisor for the aspect tolerance test.
  localparam int unsigned TOL_DIV = 100;

endpackage

// ===== rtl/core/lvf_divu.sv =====
`timescale 1ns / 1ps

// Pipelined unsigned restoring divider, one quotient bit per stage.
// It accepts one operand pair per cycle when adv is high.
module lvf_divu #(
  parameter int W = 26,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [W-1:0]  num,
  input  logic [DW-1:0] den,
  output logic [W-1:0]  quo
);

  logic [W-1:0]  rem_q [W];
  logic [W-1:0]  num_q [W];
  logic [W-1:0]  quo_q [W];
  logic [DW-1:0] den_q [W];

  // Each stage brings down one numerator bit and tries a subtract.
  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [W-1:0] rem_in;
    logic [W-1:0] num_in;
    logic [W-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [W:0]   trial;
    logic         fits;
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign num_in = num_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end
    assign trial = {rem_in, num_in[W-1]};
    assign fits  = trial >= {{(W+1-DW){1'b0}}, den_in};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[s] <= fits ? W'(trial - {{(W+1-DW){1'b0}}, den_in}) : W'(trial);
        num_q[s] <= {num_in[W-2:0], 1'b0};
        quo_q[s] <= {quo_in[W-2:0], fits};
        den_q[s] <= den_in;
      end
    end
  end

  assign quo = quo_q[W-1];

endmodule

// ===== rtl/core/letterbox_viewport_fit.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Signals
// input    | in        | in_valid, in_stall, logical_*, window_*
// result   | out       | out_valid, out_stall, out_*, offset_*, raster_*, linear_filter
// config   | in        | cfg_we, cfg_index, cfg_data
//
// One item per cycle sustained while the result is not stalled. An item passes
// 2*DIM_BITS + 5 register stages. The depth is set by the two pipelined dividers
// (aspect and integer fit) that run one quotient bit per stage.
// Reset clears all valid bits and loads fit_mode 0, native_render 1.
// A stall on the result freezes the whole pipeline; the input is stalled with it.
module letterbox_viewport_fit #(
  parameter int DIM_BITS = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [DIM_BITS-1:0]        logical_width,
  input  logic [DIM_BITS-1:0]        logical_height,
  input  logic [DIM_BITS-1:0]        window_width,
  input  logic [DIM_BITS-1:0]        window_height,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [DIM_BITS-1:0]        out_width,
  output logic [DIM_BITS-1:0]        out_height,
  output logic signed [DIM_BITS-1:0] offset_x,
  output logic signed [DIM_BITS-1:0] offset_y,
  output logic [DIM_BITS-1:0]        raster_width,
  output logic [DIM_BITS-1:0]        raster_height,
  output logic                       linear_filter,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [2:0]                 cfg_data
);

  localparam int D  = DIM_BITS;
  localparam int P  = 2 * DIM_BITS;
  localparam int PT = P + 7;          // room for 100 times a product
  localparam int DL = P;              // divider latency
  localparam int NS = DL + 5;         // total stages

  logic [2:0] fit_mode;
  logic       native_render;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode      <= lvf_pkg::MODE_KEEP_ASPECT;
      native_render <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == lvf_pkg::REG_FIT_MODE) fit_mode <= cfg_data;
      else native_render <= cfg_data[0];
    end
  end

  logic adv;
  logic [NS-1:0] vld;
  assign adv      = !(vld[NS-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NS-2:0], in_valid};
  end

  // Stage 1: default sizes and the three products.
  logic [D-1:0] s1_lw, s1_lh, s1_ww, s1_wh;
  logic [P-1:0] s1_wf, s1_hf, s1_area;
  logic [D-1:0] lw0, lh0, ww0, wh0;
  always_comb begin
    lw0 = (logical_width == '0) ? D'(1) : logical_width;
    lh0 = (logical_height == '0) ? D'(1) : logical_height;
    if (window_width == '0 || window_height == '0) begin
      ww0 = lw0;
      wh0 = lh0;
    end else begin
      ww0 = window_width;
      wh0 = window_height;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_lw <= lw0; s1_lh <= lh0; s1_ww <= ww0; s1_wh <= wh0;
      s1_wf <= lw0 * wh0;
      s1_hf <= lh0 * ww0;
      s1_area <= lh0 * wh0;
    end
  end

  // Stage 2: pick numerators and divisors for both dividers, and take the aspect difference.
  logic [P-1:0] div_a_num, div_b_num;
  logic [D-1:0] div_a_den, div_b_den;
  logic         s2_wlt;
  logic [P-1:0] s2_diff, s2_area;
  logic [D-1:0] s2_lw, s2_lh, s2_ww, s2_wh;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_wlt  <= s1_wf < s1_hf;
      s2_diff <= (s1_wf > s1_hf) ? s1_wf - s1_hf : s1_hf - s1_wf;
      s2_area <= s1_area;
      s2_lw <= s1_lw; s2_lh <= s1_lh; s2_ww <= s1_ww; s2_wh <= s1_wh;
      div_b_num <= P'(s1_wh); div_b_den <= s1_lh;
      if (fit_mode == lvf_pkg::MODE_CENTER_INT) begin
        div_a_num <= P'(s1_ww); div_a_den <= s1_lw;
      end else begin
        div_a_num <= (s1_wf < s1_hf) ? s1_wf : s1_hf;
        div_a_den <= (s1_wf < s1_hf) ? s1_lh : s1_lw;
      end
    end
  end

  logic [P-1:0] quo_a, quo_b;
  lvf_divu #(.W(P), .DW(D)) u_div_a (
    .clk(clk), .adv(adv), .num(div_a_num), .den(div_a_den), .quo(quo_a));
  lvf_divu #(.W(P), .DW(D)) u_div_b (
    .clk(clk), .adv(adv), .num(div_b_num), .den(div_b_den), .quo(quo_b));

  // Side data delayed to match the divider. The aspect error is past one percent
  // when diff > area / 100 with a truncated quotient, which for integers is the
  // same as area < 100 * diff.
  logic         dl_wlt [DL];
  logic         dl_big [DL];
  logic [D-1:0] dl_lw [DL], dl_lh [DL], dl_ww [DL], dl_wh [DL];
  always_ff @(posedge clk) begin
    if (adv) begin
      dl_wlt[0] <= s2_wlt;
      dl_big[0] <= (PT'(s2_diff) * PT'(lvf_pkg::TOL_DIV)) > PT'(s2_area);
      dl_lw[0] <= s2_lw; dl_lh[0] <= s2_lh; dl_ww[0] <= s2_ww; dl_wh[0] <= s2_wh;
      for (int i = 1; i < DL; i++) begin
        dl_wlt[i] <= dl_wlt[i-1]; dl_big[i] <= dl_big[i-1];
        dl_lw[i] <= dl_lw[i-1]; dl_lh[i] <= dl_lh[i-1];
        dl_ww[i] <= dl_ww[i-1]; dl_wh[i] <= dl_wh[i-1];
      end
    end
  end

  // Stage 3: blit size per mode (integer mode keeps the factor for a multiply).
  logic [D-1:0] t_lw, t_lh, t_ww, t_wh;
  logic [D-1:0] s3_bw, s3_bh, s3_lw, s3_lh, s3_ww, s3_wh, s3_fac;
  logic         s3_mul;
  logic [P-1:0] fit;
  assign t_lw = dl_lw[DL-1];
  assign t_lh = dl_lh[DL-1];
  assign t_ww = dl_ww[DL-1];
  assign t_wh = dl_wh[DL-1];
  assign fit  = (quo_a < quo_b) ? quo_a : quo_b;
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_lw <= t_lw; s3_lh <= t_lh; s3_ww <= t_ww; s3_wh <= t_wh;
      s3_mul <= 1'b0;
      s3_fac <= D'(1);
      s3_bw <= t_ww; s3_bh <= t_wh;
      unique case (fit_mode)
        lvf_pkg::MODE_CENTER: begin
          s3_bw <= t_lw; s3_bh <= t_lh;
        end
        lvf_pkg::MODE_CENTER_INT: begin
          s3_mul <= 1'b1;
          s3_fac <= (fit > P'(1)) ? D'(fit) : D'(1);
        end
        lvf_pkg::MODE_KEEP_ASPECT: begin
          if (dl_big[DL-1]) begin
            if (dl_wlt[DL-1]) s3_bw <= D'(quo_a);
            else s3_bh <= D'(quo_a);
          end
        end
        default: ;
      endcase
    end
  end

  // Stage 4: integer scale multiply.
  logic [D-1:0] s4_bw, s4_bh, s4_lw, s4_lh, s4_ww, s4_wh;
  logic [P-1:0] pw, ph;
  assign pw = s3_lw * s3_fac;
  assign ph = s3_lh * s3_fac;
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_bw <= s3_mul ? D'(pw) : s3_bw;
      s4_bh <= s3_mul ? D'(ph) : s3_bh;
      s4_lw <= s3_lw; s4_lh <= s3_lh; s4_ww <= s3_ww; s4_wh <= s3_wh;
    end
  end

  // Stage 5: offsets, render size and filter; this is the output register.
  logic signed [P-1:0] dx, dy, hx, hy;
  logic [D-1:0] rw, rh;
  always_comb begin
    dx = $signed(P'(s4_ww)) - $signed(P'(s4_bw));
    dy = $signed(P'(s4_wh)) - $signed(P'(s4_bh));
    hx = (dx + $signed(P'(dx[P-1]))) >>> 1;
    hy = (dy + $signed(P'(dy[P-1]))) >>> 1;
    rw = native_render ? s4_bw : s4_lw;
    rh = native_render ? s4_bh : s4_lh;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_width     <= s4_bw;
      out_height    <= s4_bh;
      offset_x      <= D'(hx);
      offset_y      <= D'(hy);
      raster_width  <= rw;
      raster_height <= rh;
      linear_filter <= (rw > s4_bw) || (rh > s4_bh);
    end
  end

endmodule

// ===== test/viewport_checker.sv =====
`timescale 1ns / 1ps

module viewport_checker #(
  parameter int DIM_BITS = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [DIM_BITS-1:0]        logical_width,
  input  logic [DIM_BITS-1:0]        logical_height,
  input  logic [DIM_BITS-1:0]        window_width,
  input  logic [DIM_BITS-1:0]        window_height,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [DIM_BITS-1:0]        out_width,
  input  logic [DIM_BITS-1:0]        out_height,
  input  logic signed [DIM_BITS-1:0] offset_x,
  input  logic signed [DIM_BITS-1:0] offset_y,
  input  logic [DIM_BITS-1:0]        raster_width,
  input  logic [DIM_BITS-1:0]        raster_height,
  input  logic                       linear_filter,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [2:0]                 cfg_data,
  output int                         mismatches,
  output int                         pending,
  output int                         rects_seen
);

  typedef struct packed {
    logic [DIM_BITS-1:0] bw;
    logic [DIM_BITS-1:0] bh;
    logic [DIM_BITS-1:0] ox;
    logic [DIM_BITS-1:0] oy;
    logic [DIM_BITS-1:0] rw;
    logic [DIM_BITS-1:0] rh;
    logic                lin;
  } rect_t;

  rect_t       rect_queue[$];
  logic [2:0]  mode_q;
  logic        native_q;

  // Compute the blit rectangle for one size pair under the current settings.
  function automatic rect_t fit_rect(input logic [DIM_BITS-1:0] lwi, lhi, wwi, whi);
    longint lw, lh, ww, wh, bw, bh, rw, rh, fx, fy, fac, wf, hf, diff, ox, oy;
    rect_t r;
    lw = longint'(lwi);
    lh = longint'(lhi);
    if (lw == 0) lw = 1;
    if (lh == 0) lh = 1;
    ww = longint'(wwi);
    wh = longint'(whi);
    if (ww == 0 || wh == 0) begin
      ww = lw;
      wh = lh;
    end
    if (mode_q == lvf_pkg::MODE_CENTER || mode_q == lvf_pkg::MODE_CENTER_INT) begin
      fac = 1;
      if (mode_q == lvf_pkg::MODE_CENTER_INT) begin
        fx = ww / lw;
        fy = wh / lh;
        fac = (fx < fy) ? fx : fy;
        if (fac < 1) fac = 1;
      end
      bw = lw * fac;
      bh = lh * fac;
    end else begin
      bw = ww;
      bh = wh;
      if (mode_q == lvf_pkg::MODE_KEEP_ASPECT) begin
        wf = lw * bh;
        hf = lh * bw;
        diff = (wf > hf) ? wf - hf : hf - wf;
        if (diff > (lh * bh) / longint'(lvf_pkg::TOL_DIV)) begin
          if (wf < hf) bw = wf / lh;
          else bh = hf / lw;
        end
      end
    end
    rw = native_q ? bw : lw;
    rh = native_q ? bh : lh;
    ox = (ww - bw) / 2;
    oy = (wh - bh) / 2;
    r.bw = bw[DIM_BITS-1:0];
    r.bh = bh[DIM_BITS-1:0];
    r.ox = ox[DIM_BITS-1:0];
    r.oy = oy[DIM_BITS-1:0];
    r.rw = rw[DIM_BITS-1:0];
    r.rh = rh[DIM_BITS-1:0];
    r.lin = (rw > bw) || (rh > bh);
    return r;
  endfunction

  // Track settings, predict on each input transfer, compare on each result transfer.
  always @(posedge clk) begin
    rect_t got, want;
    if (rst) begin
      mode_q <= lvf_pkg::MODE_KEEP_ASPECT;
      native_q <= 1'b1;
      rect_queue.delete();
      mismatches <= 0;
      pending <= 0;
      rects_seen <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lvf_pkg::REG_FIT_MODE) mode_q <= cfg_data;
        else native_q <= cfg_data[0];
      end
      if (in_valid && !in_stall)
        rect_queue.push_back(fit_rect(logical_width, logical_height,
                                      window_width, window_height));
      if (out_valid && !out_stall) begin
        rects_seen <= rects_seen + 1;
        got = {out_width, out_height, offset_x, offset_y, raster_width, raster_height,
               linear_filter};
        if (rect_queue.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transfer %h", got);
          mismatches <= mismatches + 1;
        end else begin
          want = rect_queue.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("mismatch: exp w%0d h%0d x%0d y%0d rw%0d rh%0d f%0d",
                want.bw, want.bh, $signed(want.ox), $signed(want.oy), want.rw,
                want.rh, want.lin);
              $display("          got w%0d h%0d x%0d y%0d rw%0d rh%0d f%0d",
                got.bw, got.bh, $signed(got.ox), $signed(got.oy), got.rw,
                got.rh, got.lin);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= rect_queue.size();
    end
  end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int DW = 13;
  localparam int LATENCY = 2 * DW + 5;
  localparam int WATCHDOG = 2000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [DW-1:0] logical_width = '0, logical_height = '0;
  logic [DW-1:0] window_width = '0, window_height = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [DW-1:0] out_width, out_height, raster_width, raster_height;
  logic signed [DW-1:0] offset_x, offset_y;
  logic          linear_filter;
  logic          cfg_we = 1'b0;
  logic          cfg_index = lvf_pkg::REG_FIT_MODE;
  logic [2:0]    cfg_data = '0;
  int            mismatches, pending, rects_seen;
  int            idle_cycles = 0;
  int            sent = 0;

  always #5 clk = ~clk;

  letterbox_viewport_fit #(.DIM_BITS(DW)) dut (.*);

  viewport_checker #(.DIM_BITS(DW)) checker_i (.*);

  // Receiver raises out_stall at random, or not at all, before each result transfer.
  initial begin
    int w;
    forever begin
      @(negedge clk);
      w = $urandom_range(0, 3);
      if ($urandom_range(0, 9) < 3) w = 0;
      out_stall <= (w != 0);
      repeat (w) @(negedge clk);
      if (w != 0) out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog on cycles with no transfer at all.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("tb_top failed");
      $finish;
    end
  end

  // One input transfer, after a random gap when gaps is set; valid stays high for a following item.
  task automatic send_size(input logic [DW-1:0] lw, lh, ww, wh, input bit gaps);
    int g;
    g = gaps ? $urandom_range(0, 3) : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    logical_width <= lw;
    logical_height <= lh;
    window_width <= ww;
    window_height <= wh;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  // Wait until every result has arrived and the pipeline has drained.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0 || in_valid);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [2:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [DW-1:0] rand_dim(input bit allow_zero);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return allow_zero ? DW'(0) : DW'(1);
    if (k < 4) return DW'($urandom_range(1, 64));
    if (k < 6) return DW'($urandom_range(1, 8191));
    return DW'($urandom_range(200, 2000));
  endfunction

  initial begin
    logic [DW-1:0] lw, lh, ww, wh;
    int m;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed sizes at reset settings, then under every mode.
    for (m = 0; m < 5; m++) begin
      if (m > 0) begin
        drain();
        write_reg(lvf_pkg::REG_FIT_MODE, m[2:0]);
        write_reg(lvf_pkg::REG_NATIVE_RENDER, {2'b00, m[0]});
      end
      send_size(13'd640, 13'd480, 13'd0, 13'd600, 1'b0);
      send_size(13'd8191, 13'd8191, 13'd8191, 13'd8191, 1'b0);
      send_size(13'd1, 13'd1, 13'd8191, 13'd1, 1'b1);
      send_size(13'd320, 13'd240, 13'd800, 13'd600, 1'b1);
      send_size(13'd320, 13'd240, 13'd804, 13'd600, 1'b1);
      send_size(13'd640, 13'd480, 13'd300, 13'd200, 1'b1);
      send_size(13'd0, 13'd0, 13'd5, 13'd0, 1'b1);
    end

    // Random phases across every mode code and both render settings, extremes included.
    for (m = 0; m < 16; m++) begin
      drain();
      write_reg(lvf_pkg::REG_FIT_MODE, (m < 8) ? m[2:0] : 3'($urandom_range(0, 7)));
      write_reg(lvf_pkg::REG_NATIVE_RENDER, {2'b00, m[3] ^ m[0]});
      repeat (70) begin
        lw = rand_dim(1'b0);
        lh = rand_dim(1'b0);
        if ($urandom_range(0, 3) == 0) begin
          // Near-aspect window to probe the one percent tolerance.
          ww = DW'(lw * (1 + $urandom_range(0, 3)) + $urandom_range(0, 4));
          wh = DW'(lh * (1 + $urandom_range(0, 3)));
        end else begin
          ww = rand_dim(1'b1);
          wh = rand_dim(1'b1);
        end
        send_size(lw, lh, ww, wh, $urandom_range(0, 4) != 0);
      end
    end

    drain();
    $display("covered %0d size pairs over all scaling modes and both render settings", sent);
    $display("%0d results checked, %0d mismatches", rects_seen, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end
endmodule
